@@ design/aadc_pkg.sv @@
package aadc_pkg;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_DISARMED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARMED     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIGGERED = 2'd2;

  localparam logic [INDEX_W-1:0] REG_LONG_PRESS   = 8'd0;
  localparam logic [INDEX_W-1:0] REG_DEBOUNCE     = 8'd1;
  localparam logic [INDEX_W-1:0] REG_BLINK_PERIOD = 8'd2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd3000;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [CFG_W-1:0] BLINK_PERIOD_RESET = 16'd1000;

  typedef struct packed {
    logic button_level;
    logic motion_level;
  } sample_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              red_led;
    logic              blue_led;
    logic              green_led;
  } status_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;
  } cfg_write_t;

endpackage

@@ design/aadc_stream_if.sv @@
interface aadc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/alarm_arm_disarm_controller.sv @@
// Each accepted sample's status transaction is registered into the output buffer.
// Throughput: one sample per cycle; a two-entry output buffer keeps accepting
// while one status transaction waits, and holds off input only when both are full.
// Reset (rst, synchronous): mode disarmed, timers and edge history cleared,
// LEDs off, registers at 3000 / 50 / 1000 ms, output buffer empty.
module alarm_arm_disarm_controller #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  aadc_stream_if.sink          samples,
  aadc_stream_if.source        status,
  aadc_stream_if.sink          cfg
);

  localparam int unsigned CMP_W =
    (TIMER_BITS > aadc_pkg::CFG_W) ? TIMER_BITS : aadc_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [aadc_pkg::CFG_W-1:0] long_press_ms;
  logic [aadc_pkg::CFG_W-1:0] debounce_ms;
  logic [aadc_pkg::CFG_W-1:0] blink_period_ms;

  logic [aadc_pkg::MODE_W-1:0] alarm_mode, alarm_mode_next;
  logic [TIMER_BITS-1:0]       press_elapsed, press_elapsed_next;
  logic [TIMER_BITS-1:0]       blink_elapsed, blink_elapsed_next;
  logic button_prev, motion_prev;
  logic motion_pending, motion_pending_next;
  logic short_pending, short_pending_next;
  logic blue_state, blue_state_next;
  logic green_state, green_state_next;

  aadc_pkg::status_t result_next;
  aadc_pkg::status_t out_data, skid_data;
  logic out_valid, skid_valid;

  aadc_pkg::sample_t      sample;
  aadc_pkg::cfg_write_t   cfg_wr;

  logic accept, pop;
  logic btn, mot, rise, fall, long_hold;
  logic [CMP_W-1:0] press_cmp, blink_cmp, long_cmp, deb_cmp, period_cmp;

  assign sample = samples.data;
  assign cfg_wr = cfg.data;
  assign btn    = sample.button_level;
  assign mot    = sample.motion_level;

  assign samples.ready = !skid_valid;
  assign cfg.ready     = 1'b1;
  assign accept        = samples.valid && !skid_valid;
  assign pop           = out_valid && status.ready;

  assign status.valid = out_valid;
  assign status.data  = out_data;

  assign rise = btn && !button_prev;
  assign fall = !btn && button_prev;

  always_comb begin
    press_elapsed_next  = (press_elapsed == TIMER_MAX) ? press_elapsed
                                                       : press_elapsed + 1'b1;
    blink_elapsed_next  = (blink_elapsed == TIMER_MAX) ? blink_elapsed
                                                       : blink_elapsed + 1'b1;
    if (rise) begin
      press_elapsed_next = '0;
    end

    press_cmp  = CMP_W'(press_elapsed_next);
    blink_cmp  = CMP_W'(blink_elapsed_next);
    long_cmp   = CMP_W'(long_press_ms);
    deb_cmp    = CMP_W'(debounce_ms);
    period_cmp = CMP_W'(blink_period_ms);

    short_pending_next  = short_pending
                          || (fall && (press_cmp > deb_cmp) && (press_cmp < long_cmp));
    motion_pending_next = motion_pending || (mot && !motion_prev);
    long_hold           = btn && (press_cmp >= long_cmp);

    alarm_mode_next  = alarm_mode;
    blue_state_next  = blue_state;
    green_state_next = green_state;

    unique case (alarm_mode)
      aadc_pkg::MODE_ARMED: begin
        if (long_hold) begin
          alarm_mode_next  = aadc_pkg::MODE_DISARMED;
          blue_state_next  = 1'b0;
          green_state_next = 1'b0;
        end else if (motion_pending_next) begin
          motion_pending_next = 1'b0;
          alarm_mode_next     = aadc_pkg::MODE_TRIGGERED;
          blue_state_next     = 1'b0;
          green_state_next    = 1'b0;
        end else if (blink_cmp >= period_cmp) begin
          blue_state_next    = !blue_state;
          green_state_next   = !green_state;
          blink_elapsed_next = '0;
        end
        short_pending_next = 1'b0;
      end
      aadc_pkg::MODE_DISARMED: begin
        blue_state_next  = 1'b0;
        green_state_next = 1'b0;
        if (short_pending_next) begin
          short_pending_next = 1'b0;
          alarm_mode_next    = aadc_pkg::MODE_ARMED;
          blue_state_next    = 1'b1;
          blink_elapsed_next = '0;
        end
        motion_pending_next = 1'b0;
      end
      default: begin
        blue_state_next  = 1'b0;
        green_state_next = 1'b0;
        if (short_pending_next) begin
          short_pending_next = 1'b0;
          alarm_mode_next    = aadc_pkg::MODE_ARMED;
          blue_state_next    = 1'b1;
          blink_elapsed_next = '0;
        end else if (long_hold) begin
          alarm_mode_next = aadc_pkg::MODE_DISARMED;
        end
        motion_pending_next = 1'b0;
      end
    endcase

    result_next.mode      = alarm_mode_next;
    result_next.red_led   = (alarm_mode_next == aadc_pkg::MODE_TRIGGERED);
    result_next.blue_led  = blue_state_next;
    result_next.green_led = green_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms   <= aadc_pkg::LONG_PRESS_RESET;
      debounce_ms     <= aadc_pkg::DEBOUNCE_RESET;
      blink_period_ms <= aadc_pkg::BLINK_PERIOD_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_wr.index)
        aadc_pkg::REG_LONG_PRESS:   long_press_ms   <= cfg_wr.data;
        aadc_pkg::REG_DEBOUNCE:     debounce_ms     <= cfg_wr.data;
        aadc_pkg::REG_BLINK_PERIOD: blink_period_ms <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_mode     <= aadc_pkg::MODE_DISARMED;
      press_elapsed  <= '0;
      blink_elapsed  <= '0;
      button_prev    <= 1'b0;
      motion_prev    <= 1'b0;
      motion_pending <= 1'b0;
      short_pending  <= 1'b0;
      blue_state     <= 1'b0;
      green_state    <= 1'b0;
    end else if (accept) begin
      alarm_mode     <= alarm_mode_next;
      press_elapsed  <= press_elapsed_next;
      blink_elapsed  <= blink_elapsed_next;
      button_prev    <= btn;
      motion_prev    <= mot;
      motion_pending <= motion_pending_next;
      short_pending  <= short_pending_next;
      blue_state     <= blue_state_next;
      green_state    <= green_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result_next;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data <= result_next;
      end else begin
        out_data <= result_next;
      end
    end
  end

endmodule
